// File: design/unique_id_fifo_macros.svh
// assertion macros used by the checker file
`ifndef UNIQUE_ID_FIFO_MACROS_SVH
`define UNIQUE_ID_FIFO_MACROS_SVH

// clocked property, ignored while reset is high
`define UIDF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds during reset
`define UIDF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/uidf_pkg.sv
`timescale 1ns / 1ps

package uidf_pkg;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } uidf_state_t;

  // commit pulses sent down the row of cells
  typedef struct packed {
    logic push;
    logic pop;
  } uidf_ctl_t;

endpackage

// File: design/uidf_cell.sv
`timescale 1ns / 1ps

module uidf_cell #(
  parameter int KEY_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  uidf_pkg::uidf_ctl_t ctl,
  input  logic [KEY_W-1:0]   key,
  input  logic               down_valid,
  input  logic               up_valid,
  input  logic [KEY_W-1:0]   up_data,
  output logic               valid,
  output logic [KEY_W-1:0]   data,
  output logic               match
);
  import uidf_pkg::*;

  logic load_here;

  // first empty cell on the tail side of the filled run takes the new entry
  assign load_here = ctl.push && !valid && down_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= up_valid;
    end else if (load_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= up_data;
    end else if (load_here) begin
      data <= key;
    end
  end

  always_ff @(posedge clk) begin
    match <= valid && (data == key);
  end

endmodule

// File: design/unique_id_fifo.sv
`timescale 1ns / 1ps

// channel | handshake             | payload
// req     | req_valid, req_stall  | cmd, ident
// rsp     | rsp_valid, rsp_stall  | status, ident_out, occupancy, is_empty
//
// an item goes through accept, per-cell compare into the match registers,
// then commit; the next transaction is taken the cycle after commit
// the compare is registered in every cell before the duplicate decision
// reset clears the state machine, the count, the result valid and every cell
// valid bit; cell data is not cleared
// a stalled result holds in the output register and the commit waits for it

module unique_id_fifo #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        cmd,
  input  logic [15:0] ident,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] ident_out,
  output logic [4:0]  occupancy,
  output logic        is_empty
);
  import uidf_pkg::*;

  localparam int KEY_W = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uidf_state_t      state, state_next;
  logic             op_cmd;
  logic [KEY_W-1:0] op_key;
  logic [CNT_W-1:0] held, held_next;

  uidf_ctl_t        ctl;
  logic             commit;
  logic             out_free;
  logic             dup;
  logic             full;
  logic [1:0]       status_next;

  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_match;
  logic [KEY_W-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             down_v;
    logic             up_v;
    logic [KEY_W-1:0] up_d;

    if (i == 0) begin : g_head
      assign down_v = 1'b1;
    end else begin : g_body
      assign down_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign up_v = 1'b0;
      assign up_d = '0;
    end else begin : g_inner
      assign up_v = cell_valid[i+1];
      assign up_d = cell_data[i+1];
    end

    uidf_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (op_key),
      .down_valid (down_v),
      .up_valid   (up_v),
      .up_data    (up_d),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  assign dup      = |cell_match;
  assign full     = (held == CNT_W'(DEPTH));
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall   = (state != S_IDLE);
    commit      = (state == S_COMMIT) && out_free;
    ctl.push    = 1'b0;
    ctl.pop     = 1'b0;
    status_next = ST_OK;
    // duplicate check wins over full
    if (op_cmd == CMD_ENQ) begin
      if (dup) begin
        status_next = ST_DUP;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        ctl.push = commit;
      end
    end else begin
      if (held == '0) begin
        status_next = ST_EMPTY;
      end else begin
        ctl.pop = commit;
      end
    end
  end

  always_comb begin
    held_next = held;
    if (ctl.push) begin
      held_next = held + CNT_W'(1);
    end else if (ctl.pop) begin
      held_next = held - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
    end else begin
      state <= state_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      op_cmd <= cmd;
      op_key <= ident[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status    <= status_next;
      ident_out <= ctl.pop ? 16'(cell_data[0]) : 16'd0;
      occupancy <= 5'(held_next);
      is_empty  <= (held_next == '0);
    end
  end

endmodule

// File: design/uidf_checker.sv
`timescale 1ns / 1ps
`include "unique_id_fifo_macros.svh"

module uidf_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic [15:0] ident_out,
  input logic [4:0]  occupancy,
  input logic        is_empty
);
  import uidf_pkg::*;

  logic [23:0] rsp_payload;

  assign rsp_payload = {status, ident_out, occupancy, is_empty};

  // one transaction at a time: the request side closes right after an accept
  property p_one_at_a_time;
    (req_valid && !req_stall) |=> req_stall;
  endproperty

  // a stalled result keeps its payload
  property p_rsp_hold;
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload));
  endproperty

  property p_empty_count;
    (rsp_valid && is_empty) |-> (occupancy == 5'd0);
  endproperty

  // rejected or empty results carry no identifier
  property p_no_ident;
    (rsp_valid && status != ST_OK) |-> (ident_out == 16'd0);
  endproperty

  property p_full_count;
    (rsp_valid && status == ST_FULL) |-> (occupancy == 5'(DEPTH) && !is_empty);
  endproperty

  `UIDF_ASSERT(a_one_at_a_time, clk, rst, p_one_at_a_time, "request taken while busy")
  `UIDF_ASSERT(a_rsp_hold, clk, rst, p_rsp_hold, "stalled result changed")
  `UIDF_ASSERT(a_empty_count, clk, rst, p_empty_count, "empty flag with nonzero occupancy")
  `UIDF_ASSERT(a_no_ident, clk, rst, p_no_ident, "identifier on a failed transaction")
  `UIDF_ASSERT(a_full_count, clk, rst, p_full_count, "full rejection below capacity")

endmodule

bind unique_id_fifo uidf_checker #(.DEPTH(DEPTH)) u_uidf_checker (.*);

// File: bench/unique_id_fifo_tb.sv
`timescale 1ns / 1ps

module unique_id_fifo_tb;
  import uidf_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ident_out;
    logic [4:0]  occupancy;
    logic        is_empty;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        cmd = CMD_ENQ;
  logic [15:0] ident = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] ident_out;
  logic [4:0]  occupancy;
  logic        is_empty;

  outcome_t    pending_outcomes[$];
  outcome_t    oldest_outcome;
  logic [15:0] queued_ids[$];
  int          mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          rsp_gaps = 1'b1;
  int          stall_run = 0;

  unique_id_fifo #(
    .DEPTH  (DEPTH),
    .ID_BITS(16)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd      (cmd),
    .ident    (ident),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .ident_out(ident_out),
    .occupancy(occupancy),
    .is_empty (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // queue behavior: duplicate check first, then capacity
  function automatic outcome_t fifo_outcome(logic op, logic [15:0] id);
    outcome_t o;
    bit present;
    present = 1'b0;
    o.status = ST_OK;
    o.ident_out = '0;
    foreach (queued_ids[i])
      if (queued_ids[i] == id) present = 1'b1;
    if (op == CMD_ENQ) begin
      if (present) o.status = ST_DUP;
      else if (queued_ids.size() >= DEPTH) o.status = ST_FULL;
      else queued_ids.push_back(id);
    end else if (queued_ids.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.ident_out = queued_ids.pop_front();
    end
    o.occupancy = 5'(queued_ids.size());
    o.is_empty = (queued_ids.size() == 0);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_op(logic op, logic [15:0] id);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    cmd <= op;
    ident <= id;
    do @(posedge clk); while (req_stall);
    pending_outcomes.push_back(fifo_outcome(op, id));
    gap = send_gaps ? pick_idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      cmd <= 1'($urandom_range(0, 1));
      ident <= 16'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (stall_run > 0) begin
      rsp_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (rsp_gaps) stall_run <= pick_idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (status !== oldest_outcome.status)
          report_mismatch($sformatf("status %0d, want %0d", status, oldest_outcome.status));
        if (ident_out !== oldest_outcome.ident_out)
          report_mismatch($sformatf("ident_out %h, want %h", ident_out,
                                    oldest_outcome.ident_out));
        if (occupancy !== oldest_outcome.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy,
                                    oldest_outcome.occupancy));
        if (is_empty !== oldest_outcome.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", is_empty,
                                    oldest_outcome.is_empty));
      end
    end
  end

  task automatic test_empty_dequeue();
    send_op(CMD_DEQ, 16'hFFFF);
  endtask

  task automatic test_ident_extremes();
    send_op(CMD_ENQ, 16'h0000);
    send_op(CMD_ENQ, 16'hFFFF);
    send_op(CMD_ENQ, 16'h0000);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_DEQ, 16'h0000);
  endtask

  // fill to capacity, then a fresh id and a duplicate while full
  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++) send_op(CMD_ENQ, 16'(16'h1000 + i));
    send_op(CMD_ENQ, 16'h2000);
    send_op(CMD_ENQ, 16'h1005);
  endtask

  // phases lean toward filling, balance or draining so the shifting queue hits full
  task automatic test_random_traffic(int n_items);
    int sent;
    int span;
    int enq_pct;
    int r;
    logic op;
    logic [15:0] id;
    sent = 0;
    while (sent < n_items) begin
      span = $urandom_range(15, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 20;
      endcase
      send_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        op = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        r = $urandom_range(0, 99);
        if (r < 25 && queued_ids.size() > 0)
          id = queued_ids[$urandom_range(0, queued_ids.size() - 1)];
        else if (r < 65)
          id = 16'($urandom_range(0, 31));
        else
          id = 16'($urandom);
        send_op(op, id);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_dequeue();
    test_ident_extremes();
    test_fill_and_overflow();
    test_random_traffic(1525);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
